@@ sv/lrd_pkg.sv @@
package lrd_pkg;

	// field widths fixed by the interface
	localparam int COORD_BITS    = 12;
	localparam int PIX_W         = COORD_BITS + 1;
	localparam int FRAC_BITS_DEF = 16;
	localparam int OFS_W         = 8;
	localparam int CFG_IDX_W     = 2;

	// register reset values
	localparam logic [OFS_W-1:0] X_OFFSET_RST = OFS_W'(63);
	localparam logic [OFS_W-1:0] Y_OFFSET_RST = OFS_W'(31);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = CFG_IDX_W'(1);

	// command codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// walk mode of the loaded line
	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_VERT,
		MODE_HORZ,
		MODE_DIAG
	} mode_t;

	// command word
	typedef struct packed {
		logic                  action;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
	} cmd_t;

	// result word
	typedef struct packed {
		logic             pixel_valid;
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic             done_res;
	} res_t;

	// divider start request: magnitudes of row and column spans
	typedef struct packed {
		logic             start;
		logic [PIX_W-1:0] num;
		logic [PIX_W-1:0] den;
	} div_req_t;

endpackage

@@ sv/lrd_div.sv @@
module lrd_div #(
	parameter int FRAC_BITS = lrd_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lrd_pkg::div_req_t                   req,
	output logic                                busy,
	output logic [lrd_pkg::PIX_W+FRAC_BITS-1:0] quot
);

	localparam int PW    = lrd_pkg::PIX_W;
	localparam int QW    = PW + FRAC_BITS;
	localparam int CNT_W = $clog2(QW + 1);
	localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(QW);

	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]    rem_q;
	logic [PW-1:0]    den_q;
	logic [QW-1:0]    quo_q;
	logic [PW:0]      shifted;
	logic [PW+1:0]    trial;

	// restoring step: bring in next dividend bit, try the subtract
	assign shifted = {rem_q, quo_q[QW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	assign busy = (cnt_q != '0);
	assign quot = quo_q;

	// iteration counter, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= CNT_INIT;
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= {req.num, {FRAC_BITS{1'b0}}};
		end else if (busy) begin
			if (!trial[PW+1]) begin
				rem_q <= trial[PW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[PW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

endmodule

@@ sv/lrd_walk.sv @@
module lrd_walk #(
	parameter int FRAC_BITS = lrd_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  lrd_pkg::cmd_t             cmd,
	input  logic [lrd_pkg::OFS_W-1:0] x_offset,
	input  logic [lrd_pkg::OFS_W-1:0] y_offset,
	output lrd_pkg::res_t             result,
	output logic                      busy
);

	localparam int PW = lrd_pkg::PIX_W;
	localparam int QW = PW + FRAC_BITS;
	localparam int DW = QW + 2;
	localparam logic [DW-1:0] ONE_FX = DW'(1) << FRAC_BITS;

	// line state
	lrd_pkg::mode_t mode_q, mode_d;
	logic           fill_q, fill_d;
	logic           east_q, east_d;
	logic           south_q, south_d;
	logic [PW-1:0]  col_q, col_d;
	logic [PW-1:0]  row_q, row_d;
	logic [PW-1:0]  ecol_q, ecol_d;
	logic [PW-1:0]  erow_q, erow_d;
	// row minus exact position, fixed point
	logic [DW-1:0]  diff_q, diff_d;

	// load decode
	logic [PW-1:0] ld_col, ld_row, ld_ecol, ld_erow;
	logic          ld_east, ld_south;

	// tick decode
	logic [QW-1:0] quot;
	logic [DW-1:0] mag;
	logic [DW-1:0] d1;
	logic [DW-1:0] diff_base;
	logic          at_end, near, due_col, due_fill;
	logic          plot, go_row, go_col, fill_tick, finish;

	lrd_pkg::div_req_t div_req;

	// true when the row still lies short of the position
	function automatic logic ahead(input logic [DW-1:0] d, input logic s);
		logic r;
		if (s) begin
			r = d[DW-1];
		end else begin
			r = !d[DW-1] && (d != '0);
		end
		return r;
	endfunction

	lrd_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.busy  (busy),
		.quot  (quot)
	);

	// endpoints after the offsets
	always_comb begin
		ld_col   = PW'(cmd.x_start) + PW'(x_offset);
		ld_row   = PW'(cmd.y_start) + PW'(y_offset);
		ld_ecol  = PW'(cmd.x_end) + PW'(x_offset);
		ld_erow  = PW'(cmd.y_end);
		ld_east  = ld_col < ld_ecol;
		ld_south = ld_row < ld_erow;
	end

	// slope division request for a sloped line
	always_comb begin
		div_req.start = accept && (cmd.action == lrd_pkg::ACT_LOAD)
			&& (ld_col != ld_ecol) && (ld_row != ld_erow);
		div_req.num   = ld_south ? (ld_erow - ld_row) : (ld_row - ld_erow);
		div_req.den   = ld_east ? (ld_ecol - ld_col) : (ld_col - ld_ecol);
	end

	// position test after the column step
	always_comb begin
		mag      = {2'b00, quot};
		d1       = south_q ? (diff_q - mag) : (diff_q + mag);
		at_end   = east_q ? (col_q >= ecol_q) : (col_q <= ecol_q);
		near     = (d1[DW-1:FRAC_BITS] == '0)
			|| ((&d1[DW-1:FRAC_BITS]) && (d1[FRAC_BITS-1:0] != '0));
		due_col  = ahead(d1, south_q);
		due_fill = ahead(diff_q, south_q);
	end

	// tick action per mode
	always_comb begin
		plot      = 1'b0;
		go_row    = 1'b0;
		go_col    = 1'b0;
		fill_tick = fill_q;
		finish    = 1'b0;
		diff_base = diff_q;
		case (mode_q)
			lrd_pkg::MODE_IDLE: begin
				finish = 1'b1;
			end
			lrd_pkg::MODE_VERT: begin
				if (row_q != erow_q) begin
					plot   = 1'b1;
					go_row = 1'b1;
				end else begin
					finish = 1'b1;
				end
			end
			lrd_pkg::MODE_HORZ: begin
				if (col_q != ecol_q) begin
					plot   = 1'b1;
					go_col = 1'b1;
				end else begin
					finish = 1'b1;
				end
			end
			lrd_pkg::MODE_DIAG: begin
				if (!fill_q) begin
					if (at_end) begin
						finish = 1'b1;
					end else begin
						diff_base = d1;
						if (near) begin
							plot      = 1'b1;
							fill_tick = 1'b1;
						end else if (due_col) begin
							plot      = 1'b1;
							go_row    = 1'b1;
							fill_tick = 1'b1;
						end else begin
							go_col = 1'b1;
						end
					end
				end else begin
					if (due_fill) begin
						plot   = 1'b1;
						go_row = 1'b1;
					end else begin
						go_col    = 1'b1;
						fill_tick = 1'b0;
					end
				end
			end
			default: begin
				finish = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		mode_d  = mode_q;
		fill_d  = fill_q;
		east_d  = east_q;
		south_d = south_q;
		col_d   = col_q;
		row_d   = row_q;
		ecol_d  = ecol_q;
		erow_d  = erow_q;
		diff_d  = diff_q;
		if (accept) begin
			if (cmd.action == lrd_pkg::ACT_LOAD) begin
				col_d   = ld_col;
				row_d   = ld_row;
				ecol_d  = ld_ecol;
				erow_d  = ld_erow;
				east_d  = ld_east;
				south_d = ld_south;
				fill_d  = 1'b0;
				diff_d  = '0;
				if (ld_col == ld_ecol) begin
					mode_d = lrd_pkg::MODE_VERT;
				end else if (ld_row == ld_erow) begin
					mode_d = lrd_pkg::MODE_HORZ;
				end else begin
					mode_d = lrd_pkg::MODE_DIAG;
				end
			end else begin
				if (finish) begin
					mode_d = lrd_pkg::MODE_IDLE;
				end
				fill_d = fill_tick;
				if (go_row) begin
					row_d = south_q ? (row_q + PW'(1)) : (row_q - PW'(1));
				end
				if (go_col) begin
					col_d = east_q ? (col_q + PW'(1)) : (col_q - PW'(1));
				end
				if (mode_q == lrd_pkg::MODE_DIAG) begin
					if (go_row) begin
						diff_d = south_q ? (diff_base + ONE_FX) : (diff_base - ONE_FX);
					end else begin
						diff_d = diff_base;
					end
				end
			end
		end
	end

	// result word
	always_comb begin
		result = '0;
		if (cmd.action == lrd_pkg::ACT_TICK) begin
			result.pixel_valid = plot;
			result.done_res    = finish;
			if (plot) begin
				result.pixel_x = col_q;
				result.pixel_y = row_q;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lrd_pkg::MODE_IDLE;
			fill_q  <= 1'b0;
			east_q  <= 1'b0;
			south_q <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			fill_q  <= fill_d;
			east_q  <= east_d;
			south_q <= south_d;
		end
	end

	// coordinates and position
	always_ff @(posedge clk) begin
		col_q  <= col_d;
		row_q  <= row_d;
		ecol_q <= ecol_d;
		erow_q <= erow_d;
		diff_q <= diff_d;
	end

endmodule

@@ sv/line_rasterizer_dda_top.sv @@
// Line rasterizer. A load word latches a line (x_offset added to both columns, y_offset
// to the start row only) and returns an all-zero result; each tick word advances the
// walk one step and returns at most one pixel, with done_res set once the line is
// exhausted. Every command word gives exactly one result word. A load of a sloped line
// starts the bit-serial slope divider, which produces one quotient bit per cycle, and
// cmd_stall is held after that load until the quotient is complete. Results sit in one
// output register; a new command word is taken while the previous result is being read
// out, and apart from the divider the block stalls only while that register is full
// and stalled.
// The configuration port is always ready and is meant to be written while idle.
module line_rasterizer_dda_top #(
	parameter int FRAC_BITS = lrd_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  lrd_pkg::cmd_t                 cmd,
	output logic                          res_valid,
	input  logic                          res_stall,
	output lrd_pkg::res_t                 res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lrd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lrd_pkg::OFS_W-1:0]     cfg_data
);

	logic [lrd_pkg::OFS_W-1:0] x_off_q;
	logic [lrd_pkg::OFS_W-1:0] y_off_q;
	logic                      res_valid_q;
	lrd_pkg::res_t             res_q;
	lrd_pkg::res_t             walk_res;
	logic                      walk_busy;
	logic                      accept;

	// handshake
	assign cfg_ready = 1'b1;
	assign cmd_stall = walk_busy || (res_valid_q && res_stall);
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	lrd_walk #(
		.FRAC_BITS(FRAC_BITS)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (cmd),
		.x_offset(x_off_q),
		.y_offset(y_off_q),
		.result  (walk_res),
		.busy    (walk_busy)
	);

	// offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q <= lrd_pkg::X_OFFSET_RST;
			y_off_q <= lrd_pkg::Y_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lrd_pkg::REG_X_OFFSET: x_off_q <= cfg_data;
				lrd_pkg::REG_Y_OFFSET: y_off_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= walk_res;
		end
	end

endmodule

@@ tb/sv/line_rasterizer_dda_top_test.sv @@
`timescale 1ns / 100ps

module line_rasterizer_dda_top_test;

	localparam int PW          = lrd_pkg::PIX_W;
	localparam int CW          = lrd_pkg::COORD_BITS;
	localparam int OW          = lrd_pkg::OFS_W;
	localparam int IW          = lrd_pkg::CFG_IDX_W;
	localparam int FRAC        = lrd_pkg::FRAC_BITS_DEF;
	localparam int MAXC        = (1 << CW) - 1;
	localparam int MAXO        = (1 << OW) - 1;
	localparam int DRAIN       = PW + FRAC + 8;
	localparam int IDLE_LIMIT  = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int WORD_TARGET = 400;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          cmd_stall;
	lrd_pkg::cmd_t cmd       = '0;
	logic          res_valid;
	logic          res_stall = 1'b0;
	lrd_pkg::res_t res;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [IW-1:0] cfg_index = '0;
	logic [OW-1:0] cfg_data  = '0;

	line_rasterizer_dda_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted walker state
	logic [OW-1:0]  ofs_x    = lrd_pkg::X_OFFSET_RST;
	logic [OW-1:0]  ofs_y    = lrd_pkg::Y_OFFSET_RST;
	logic [PW-1:0]  col_now  = '0;
	logic [PW-1:0]  row_now  = '0;
	logic [PW-1:0]  col_stop = '0;
	logic [PW-1:0]  row_stop = '0;
	longint         pos_fx   = 0;
	longint         slope_fx = 0;
	lrd_pkg::mode_t walk     = lrd_pkg::MODE_IDLE;
	logic           filling  = 1'b0;
	logic           go_east  = 1'b0;
	logic           go_south = 1'b0;
	logic           line_over = 1'b1;

	lrd_pkg::res_t pending_pixels[$];
	int   fail_count  = 0;
	int   words_sent  = 0;
	int   burst_left  = 1;
	logic cmd_up      = 1'b0;
	int   holds_asked = 0;

	initial forever #5 clk = ~clk;

	function automatic longint widen(logic [PW-1:0] v);
		longint w;
		w = v;
		return w;
	endfunction

	// row as fixed point
	function automatic longint fx(logic [PW-1:0] v);
		return widen(v) <<< FRAC;
	endfunction

	function automatic lrd_pkg::res_t here();
		lrd_pkg::res_t r;
		r             = '0;
		r.pixel_valid = 1'b1;
		r.pixel_x     = col_now;
		r.pixel_y     = row_now;
		return r;
	endfunction

	// row still short of the running position
	function automatic logic row_behind();
		return go_south ? (fx(row_now) < pos_fx) : (fx(row_now) > pos_fx);
	endfunction

	function automatic void step_row();
		row_now = go_south ? row_now + 1'b1 : row_now - 1'b1;
	endfunction

	function automatic void step_col();
		col_now = go_east ? col_now + 1'b1 : col_now - 1'b1;
	endfunction

	// next result word of the walker for one command word
	function automatic lrd_pkg::res_t rasterize_word(lrd_pkg::cmd_t w);
		lrd_pkg::res_t r;
		longint        gap;
		longint        one;
		logic          at_end;
		r   = '0;
		one = longint'(1) <<< FRAC;
		if (w.action == lrd_pkg::ACT_LOAD) begin
			col_now  = {1'b0, w.x_start} + PW'(ofs_x);
			row_now  = {1'b0, w.y_start} + PW'(ofs_y);
			col_stop = {1'b0, w.x_end} + PW'(ofs_x);
			row_stop = {1'b0, w.y_end};
			go_east  = col_now < col_stop;
			go_south = row_now < row_stop;
			pos_fx   = fx(row_now);
			slope_fx = 0;
			filling  = 1'b0;
			if (col_now == col_stop) begin
				walk = lrd_pkg::MODE_VERT;
			end else if (row_now == row_stop) begin
				walk = lrd_pkg::MODE_HORZ;
			end else begin
				slope_fx = (fx(row_stop) - fx(row_now)) / (widen(col_stop) - widen(col_now));
				walk     = lrd_pkg::MODE_DIAG;
			end
		end else begin
			case (walk)
				lrd_pkg::MODE_VERT: begin
					if (row_now != row_stop) begin
						r = here();
						step_row();
					end else begin
						walk = lrd_pkg::MODE_IDLE;
					end
				end
				lrd_pkg::MODE_HORZ: begin
					if (col_now != col_stop) begin
						r = here();
						step_col();
					end else begin
						walk = lrd_pkg::MODE_IDLE;
					end
				end
				lrd_pkg::MODE_DIAG: begin
					if (!filling) begin
						at_end = go_east ? (col_now >= col_stop) : (col_now <= col_stop);
						if (at_end) begin
							walk = lrd_pkg::MODE_IDLE;
						end else begin
							pos_fx = go_east ? pos_fx + slope_fx : pos_fx - slope_fx;
							gap    = fx(row_now) - pos_fx;
							if (gap < one && gap > -one) begin
								r       = here();
								filling = 1'b1;
							end else if (row_behind()) begin
								r = here();
								step_row();
								filling = 1'b1;
							end else begin
								step_col();
							end
						end
					end else if (row_behind()) begin
						r = here();
						step_row();
					end else begin
						step_col();
						filling = 1'b0;
					end
				end
				default: begin
					walk = lrd_pkg::MODE_IDLE;
				end
			endcase
			r.done_res = (walk == lrd_pkg::MODE_IDLE);
		end
		return r;
	endfunction

	function automatic lrd_pkg::cmd_t line_word(int xs, int ys, int xe, int ye);
		lrd_pkg::cmd_t w;
		w.action  = lrd_pkg::ACT_LOAD;
		w.x_start = xs[CW-1:0];
		w.y_start = ys[CW-1:0];
		w.x_end   = xe[CW-1:0];
		w.y_end   = ye[CW-1:0];
		return w;
	endfunction

	// tick with random coordinate bits, which the block ignores
	function automatic lrd_pkg::cmd_t tick_word();
		lrd_pkg::cmd_t w;
		w        = line_word($urandom_range(0, MAXC), $urandom_range(0, MAXC),
			$urandom_range(0, MAXC), $urandom_range(0, MAXC));
		w.action = lrd_pkg::ACT_TICK;
		return w;
	endfunction

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : ((v > MAXC) ? MAXC : v);
	endfunction

	// send one command word, predict its result, then maybe pause between bursts
	task automatic send_word(input lrd_pkg::cmd_t w);
		lrd_pkg::res_t r;
		cmd_valid <= 1'b1;
		cmd       <= w;
		cmd_up     = 1'b1;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		r = rasterize_word(w);
		pending_pixels.insert(pending_pixels.size(), r);
		line_over = (w.action == lrd_pkg::ACT_LOAD) ? 1'b0 : r.done_res;
		words_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			cmd_valid <= 1'b0;
			cmd_up     = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 10);
		end
	endtask

	// stop offering and let every outstanding word and the divider finish
	task automatic quiesce();
		if (cmd_up) begin
			cmd_valid <= 1'b0;
			cmd_up     = 1'b0;
		end
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [OW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		if (idx == lrd_pkg::REG_X_OFFSET)
			ofs_x = val;
		else if (idx == lrd_pkg::REG_Y_OFFSET)
			ofs_y = val;
		@(posedge clk);
	endtask

	task automatic set_offsets(input int xo, input int yo);
		quiesce();
		write_reg(lrd_pkg::REG_X_OFFSET, xo[OW-1:0]);
		write_reg(lrd_pkg::REG_Y_OFFSET, yo[OW-1:0]);
	endtask

	// load, tick until the walk reports done (or cap), then some trailing ticks
	task automatic run_line(input lrd_pkg::cmd_t load, input int cap, input int extra);
		int n;
		n = 0;
		send_word(load);
		while (!line_over && n < cap) begin
			send_word(tick_word());
			n++;
		end
		repeat (extra) send_word(tick_word());
	endtask

	// short well-formed line with random placement and direction
	task automatic random_line(input int span);
		int xs, ys, d, xe, ye;
		xs = $urandom_range(0, MAXC);
		ys = $urandom_range(span, MAXC - MAXO - span);
		d  = $urandom_range(0, 2 * span);
		xe = clamp_coord(xs + d - span);
		d  = $urandom_range(0, 2 * span);
		ye = clamp_coord(ys + ofs_y + d - span);
		run_line(line_word(xs, ys, xe, ye), 8 * span + 16, $urandom_range(0, 2));
	endtask

	// noise: full-range loads cut short, or stray ticks
	task automatic broken_sequence();
		if ($urandom_range(0, 1) == 0)
			run_line(line_word($urandom_range(0, MAXC), $urandom_range(0, MAXC),
				$urandom_range(0, MAXC), $urandom_range(0, MAXC)), $urandom_range(0, 6), 0);
		else
			repeat ($urandom_range(1, 3)) send_word(tick_word());
	endtask

	task automatic test_directed();
		// tick with no line loaded
		send_word(tick_word());
		// endpoints coincide after the offsets
		run_line(line_word(5, 10, 5, 10 + ofs_y), 4, 1);
		// vertical going south, horizontal going east
		run_line(line_word(0, 0, 0, 33), 8, 1);
		run_line(line_word(0, 0, 2, 31), 8, 1);
		// horizontal going west at the top of the range
		run_line(line_word(MAXC, 100, MAXC - 2, 100 + ofs_y), 8, 0);
		// steep south-east and shallow north-west slopes
		run_line(line_word(0, 0, 1, 34), 16, 1);
		run_line(line_word(2, 10, 0, 40), 16, 1);
		// field extremes, walks cut short
		run_line(line_word(MAXC, MAXC, 0, 0), 2, 0);
		run_line(line_word(0, 0, MAXC, MAXC), 2, 0);
	endtask

	task automatic test_offsets();
		int xo[4] = '{0, MAXO, 0, MAXO};
		int yo[4] = '{0, MAXO, MAXO, 0};
		logic [IW-1:0] spare;
		for (int i = 0; i < 4; i++) begin
			set_offsets(xo[i], yo[i]);
			random_line($urandom_range(1, 5));
			random_line($urandom_range(1, 5));
			run_line(line_word(MAXC, MAXC, MAXC, 0), 4, 0);
			run_line(line_word(MAXC, MAXC, MAXC - 1, 0), 4, 0);
		end
		// unmapped register indexes change nothing
		quiesce();
		spare = lrd_pkg::REG_Y_OFFSET + 1'b1;
		while (spare != lrd_pkg::REG_X_OFFSET) begin
			write_reg(spare, OW'($urandom_range(0, MAXO)));
			spare = spare + 1'b1;
		end
		random_line(4);
	endtask

	// long receiver hold-off while words keep coming
	task automatic test_backpressure();
		quiesce();
		holds_asked++;
		run_line(line_word(10, 10, 14, 10 + ofs_y + 4), 40, 2);
		repeat (6) send_word(tick_word());
	endtask

	task automatic test_random();
		int goal;
		for (int ph = 0; ph < 3; ph++) begin
			set_offsets($urandom_range(0, MAXO), $urandom_range(0, MAXO));
			goal = words_sent + (WORD_TARGET - words_sent) / (3 - ph);
			while (words_sent < goal) begin
				if ($urandom_range(0, 99) < 15)
					broken_sequence();
				else if ($urandom_range(0, 9) == 0)
					random_line($urandom_range(7, 24));
				else
					random_line($urandom_range(1, 6));
			end
		end
	endtask

	// receiver stall pattern, with a counted hold-off on request
	int          holds_seen  = 0;
	int          hold_left   = 0;
	int          style_left  = 0;
	stall_mode_t stall_style = STALL_NONE;

	always @(posedge clk) begin
		if (holds_seen != holds_asked) begin
			holds_seen <= holds_asked;
			hold_left  <= HOLD_CYCLES;
			res_stall  <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			case (stall_style)
				STALL_NONE:  res_stall <= 1'b0;
				STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
				default:     res_stall <= ~res_stall;
			endcase
		end
		if (style_left == 0) begin
			stall_style <= stall_mode_t'($urandom_range(0, 3));
			style_left  <= $urandom_range(8, 80);
		end else begin
			style_left <= style_left - 1;
		end
	end

	// compare each accepted result word with the oldest prediction
	always @(posedge clk) begin : check_res
		lrd_pkg::res_t want;
		if (arst_n && res_valid === 1'b1 && res_stall == 1'b0) begin
			if (pending_pixels.size() == 0) begin
				$error("result word with nothing pending: %p", res);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (res.pixel_valid !== want.pixel_valid) begin
					$error("pixel_valid: expected %0d, actual %0d", want.pixel_valid, res.pixel_valid);
					fail_count++;
				end
				if (res.pixel_x !== want.pixel_x) begin
					$error("pixel_x: expected %0d, actual %0d", want.pixel_x, res.pixel_x);
					fail_count++;
				end
				if (res.pixel_y !== want.pixel_y) begin
					$error("pixel_y: expected %0d, actual %0d", want.pixel_y, res.pixel_y);
					fail_count++;
				end
				if (res.done_res !== want.done_res) begin
					$error("done_res: expected %0d, actual %0d", want.done_res, res.done_res);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((cmd_valid && cmd_stall === 1'b0) || (res_valid === 1'b1 && !res_stall) ||
			(cfg_valid && cfg_ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_offsets();
		test_backpressure();
		test_random();
		quiesce();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
sv/lrd_pkg.sv
sv/lrd_div.sv
sv/lrd_walk.sv
sv/line_rasterizer_dda_top.sv
tb/sv/line_rasterizer_dda_top_test.sv
